// File: sv/chained_range_remap_top_macros.svh
// assertion macros for the chained range remap block
// used by modules that check their own logic; needs clk and arst_n in scope
`ifndef CHAINED_RANGE_REMAP_TOP_MACROS_SVH
`define CHAINED_RANGE_REMAP_TOP_MACROS_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define CRR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("crr assertion failed");
// property checked on every clock edge, reset included
`define CRR_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("crr assertion failed");
`else
`define CRR_ASSERT(lbl, prop)
`define CRR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: sv/crr_pkg.sv
// shared types for the chained range remap block
// no dependencies; imported by the front, queue, back and top modules of the block
package crr_pkg;

	localparam int WORD_W  = 32;
	localparam int STAGE_W = 3;

	// input kind codes
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_XLATE = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// one input transaction
	typedef struct packed {
		logic [1:0]         kind;
		logic [STAGE_W-1:0] stage;
		logic [WORD_W-1:0]  dest_start;
		logic [WORD_W-1:0]  src_start;
		logic [WORD_W-1:0]  span;
		logic [WORD_W-1:0]  value;
	} item_t;

	// one result transaction
	typedef struct packed {
		logic [WORD_W-1:0] final_value;
		logic [WORD_W-1:0] lowest;
	} result_t;

	// classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_XLATE
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [STAGE_W-1:0] stage;
		logic [WORD_W-1:0]  dest_start;
		logic [WORD_W-1:0]  src_start;
		logic [WORD_W-1:0]  span;
		logic [WORD_W-1:0]  value;
	} cmd_t;

	// one stored range
	typedef struct packed {
		logic [WORD_W-1:0] dest;
		logic [WORD_W-1:0] src;
		logic [WORD_W-1:0] len;
	} range_entry_t;

endpackage

// File: sv/crr_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
module crr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 448
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/crr_front.sv
// front end: accepts input transactions and classifies them into commands
// depends on crr_pkg; drops unused kinds and loads into missing stages
module crr_front import crr_pkg::*; #(
	parameter int STAGES = 7
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  cmd_valid,
	input  logic  cmd_stall,
	output cmd_t  cmd
);

	logic cmd_valid_q;
	cmd_t cmd_q;
	logic accept;
	logic dec_keep;
	op_t  dec_op;

	assign item_stall = cmd_valid_q && cmd_stall;
	assign accept     = item_valid && !item_stall;
	assign cmd_valid  = cmd_valid_q;
	assign cmd        = cmd_q;

	// kind decoder
	always_comb begin
		unique case (item.kind)
			KIND_CLEAR: begin
				dec_keep = 1'b1;
				dec_op   = OP_CLEAR;
			end
			KIND_LOAD: begin
				dec_keep = int'(item.stage) < STAGES;
				dec_op   = OP_LOAD;
			end
			KIND_XLATE: begin
				dec_keep = 1'b1;
				dec_op   = OP_XLATE;
			end
			default: begin
				dec_keep = 1'b0;
				dec_op   = OP_CLEAR;
			end
		endcase
	end

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (accept) begin
			cmd_valid_q <= dec_keep;
		end else if (!cmd_stall) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op         <= dec_op;
			cmd_q.stage      <= item.stage;
			cmd_q.dest_start <= item.dest_start;
			cmd_q.src_start  <= item.src_start;
			cmd_q.span       <= item.span;
			cmd_q.value      <= item.value;
		end
	end

endmodule

// File: sv/crr_queue.sv
// short command queue between front and back end
// depends on crr_pkg for the command type
module crr_queue import crr_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_stall,
	input  cmd_t push_data,
	input  logic pop,
	output logic empty,
	output cmd_t pop_data
);

	localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [NW-1:0] FULL_FILL = NW'(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_stall = fill_q == FULL_FILL;
	assign empty      = fill_q == '0;
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop && !empty;
	assign pop_data   = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/crr_back.sv
// back end: owns the range tables, runs loads, clears and translations
// depends on crr_pkg, crr_ram and the assertion macro header
`include "chained_range_remap_top_macros.svh"

module crr_back import crr_pkg::*; #(
	parameter int STAGES  = 7,
	parameter int ENTRIES = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  cmd_t    q_cmd,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int DEPTH = STAGES * ENTRIES;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int SW    = STAGES > 1 ? $clog2(STAGES) : 1;
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam logic [AW-1:0] STAGE_STRIDE = AW'(ENTRIES);
	localparam logic [SW-1:0] LAST_STAGE   = SW'(STAGES - 1);
	localparam logic [CW-1:0] FULL_COUNT   = CW'(ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q [STAGES];
	logic [SW-1:0]     s_q;
	logic [AW-1:0]     base_q;
	logic [CW-1:0]     idx_q;
	logic              pend_q;
	logic [WORD_W-1:0] v_q;
	logic [WORD_W-1:0] lowest_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [SW-1:0]     ld_stage;
	logic [CW-1:0]     ld_cnt;
	logic [AW-1:0]     ld_addr;
	logic              ram_we;
	range_entry_t      wr_entry;
	range_entry_t      rd_entry;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [CW-1:0]     scan_cnt;
	logic              more;
	logic [WORD_W-1:0] diff;
	logic              hit;
	logic [WORD_W-1:0] mapped;
	logic [WORD_W-1:0] new_low;

	assign q_pop        = (state_q == ST_IDLE) && !q_empty;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// load path: append at the end of the stage table
	always_comb begin
		ld_stage = SW'(q_cmd.stage);
		ld_cnt   = cnt_q[ld_stage];
		ld_addr  = AW'(int'(ld_stage) * ENTRIES) + AW'(ld_cnt);
		ram_we   = q_pop && (q_cmd.op == OP_LOAD) && (ld_cnt != FULL_COUNT);
		wr_entry.dest = q_cmd.dest_start;
		wr_entry.src  = q_cmd.src_start;
		wr_entry.len  = q_cmd.span;
	end

	// scan path: check the entry read last cycle, issue the next read
	always_comb begin
		scan_cnt = cnt_q[s_q];
		more     = idx_q < scan_cnt;
		diff     = v_q - rd_entry.src;
		hit      = pend_q && (v_q >= rd_entry.src) && (diff < rd_entry.len);
		mapped   = rd_entry.dest + diff;
		rd_en    = (state_q == ST_SCAN) && !hit && more;
		rd_addr  = base_q + AW'(idx_q);
		new_low  = (v_q < lowest_q) ? v_q : lowest_q;
	end

	crr_ram #(
		.WIDTH($bits(range_entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ld_addr),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	// sequencer, counts, running minimum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			lowest_q    <= '1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < STAGES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !result_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						unique case (q_cmd.op)
							OP_CLEAR: begin
								lowest_q <= '1;
								for (int i = 0; i < STAGES; i++) begin
									cnt_q[i] <= '0;
								end
							end
							OP_LOAD: begin
								if (ram_we) begin
									cnt_q[ld_stage] <= ld_cnt + CW'(1);
								end
							end
							OP_XLATE: begin
								v_q     <= q_cmd.value;
								s_q     <= '0;
								base_q  <= '0;
								idx_q   <= '0;
								pend_q  <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit || !more) begin
						if (hit) begin
							v_q <= mapped;
						end
						pend_q <= 1'b0;
						idx_q  <= '0;
						if (s_q == LAST_STAGE) begin
							state_q <= ST_FINISH;
						end else begin
							s_q    <= s_q + SW'(1);
							base_q <= base_q + STAGE_STRIDE;
						end
					end else begin
						idx_q  <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q       <= 1'b1;
						out_q.final_value <= v_q;
						out_q.lowest      <= new_low;
						lowest_q          <= new_low;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the scan index never runs past the stage's entry count
	`CRR_ASSERT(a_idx_in_table, (state_q == ST_SCAN) |-> (idx_q <= cnt_q[s_q]))
	// a pending compare always follows a ram read
	`CRR_ASSERT(a_pend_after_read, pend_q |-> $past(rd_en))
	// the reported minimum never exceeds the reported value
	`CRR_ASSERT(a_lowest_bound, out_valid_q |-> (out_q.lowest <= out_q.final_value))
	// a new result appears only at the end of a translation
	`CRR_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))

endmodule

// File: sv/chained_range_remap_top.sv
// top level of the chained range remap block
// depends on crr_pkg, crr_front, crr_queue and crr_back
//
// item channel (item_valid, item_stall, item) carries clear, load and
// translate transactions; result channel (result_valid, result_stall, result)
// returns one transaction per translate, with the final value and the
// minimum final value since the last clear. A transaction is taken at a clock
// edge with valid high and stall low.
// the front registers and classifies each transaction and hands it to a
// command queue of QUEUE_DEPTH entries. Clear and load are carried out by the
// back end as it pops them while idle. A translate walks the stages through
// one table ram read port, one entry a cycle; each stage ends at its first hit
// or after its last entry, and the final value then goes to the result register.
// arst_n clears all stage counts, the queue and the result register and sets
// the minimum to all ones; the tables need no clearing pass.
// a stalled result holds; the back end keeps running clears and loads and the
// next translate waits at its end, so the queue then the front fill up and
// item_stall rises.
module chained_range_remap_top import crr_pkg::*; #(
	parameter int STAGES      = 7,
	parameter int ENTRIES     = 64,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic q_empty;
	logic q_pop;
	cmd_t q_cmd;

	crr_front #(
		.STAGES(STAGES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd)
	);

	crr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(cmd_valid),
		.push_stall(cmd_stall),
		.push_data (cmd),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_cmd)
	);

	crr_back #(
		.STAGES (STAGES),
		.ENTRIES(ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// File: tb/chained_range_remap_top_test.sv
// self-checking testbench for chained_range_remap_top: directed and random
// clear/load/translate traffic with a scoreboard that predicts every result
// depends on crr_pkg and chained_range_remap_top
`timescale 1ns / 100ps

module chained_range_remap_top_test;
	import crr_pkg::*;

	localparam int STAGES      = 7;
	localparam int ENTRIES     = 64;
	localparam int ITEM_GOAL   = 750;
	localparam int QUIET_LIMIT = 12000;
	localparam int TAIL_CYCLES = STAGES * (ENTRIES + 1) + 40;
	localparam int SHOW_LIMIT  = 10;

	// stage index past the last table
	localparam logic [2:0] STAGE_BEYOND = 3'd7;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	bit          no_idle;
	int unsigned stall_left;
	int unsigned counted;

	chained_range_remap_top #(
		.STAGES(STAGES),
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// predicts translations and holds the results still owed by the block
	class remap_scoreboard;
		logic [31:0] tbl_dest [STAGES][ENTRIES];
		logic [31:0] tbl_src  [STAGES][ENTRIES];
		logic [31:0] tbl_len  [STAGES][ENTRIES];
		int unsigned fill [STAGES];
		logic [31:0] low_mark;
		result_t     owed_q [$];
		int unsigned errors, checked, stored, dropped, ignored, clears, deepest;

		function new();
			foreach (fill[s]) fill[s] = 0;
			low_mark = '1;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("mismatch: %s", msg);
		endfunction

		// first matching entry of each stage in load order, bound exclusive
		function logic [31:0] walk_chain(logic [31:0] v);
			logic [31:0] cur;
			logic [31:0] off;
			bit          hit;
			cur = v;
			for (int s = 0; s < STAGES; s++) begin
				hit = 1'b0;
				for (int e = 0; e < fill[s] && !hit; e++) begin
					off = cur - tbl_src[s][e];
					if (cur >= tbl_src[s][e] && off < tbl_len[s][e]) begin
						cur = tbl_dest[s][e] + off;
						hit = 1'b1;
					end
				end
			end
			return cur;
		endfunction

		function void note_item(item_t it);
			result_t r;
			case (it.kind)
				KIND_CLEAR: begin
					foreach (fill[s]) fill[s] = 0;
					low_mark = '1;
					clears++;
				end
				KIND_LOAD: begin
					if (it.stage >= STAGES) begin
						ignored++;
					end else if (fill[it.stage] >= ENTRIES) begin
						dropped++;
					end else begin
						tbl_dest[it.stage][fill[it.stage]] = it.dest_start;
						tbl_src[it.stage][fill[it.stage]]  = it.src_start;
						tbl_len[it.stage][fill[it.stage]]  = it.span;
						fill[it.stage]++;
						stored++;
						if (fill[it.stage] > deepest)
							deepest = fill[it.stage];
					end
				end
				KIND_XLATE: begin
					r.final_value = walk_chain(it.value);
					if (r.final_value < low_mark)
						low_mark = r.final_value;
					r.lowest = low_mark;
					owed_q.insert(owed_q.size(), r);
				end
				default: ignored++;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (owed_q.size() == 0) begin
				flag($sformatf("result with none owed: final_value %h lowest %h",
					got.final_value, got.lowest));
				return;
			end
			exp = owed_q.pop_front();
			checked++;
			if (got.final_value !== exp.final_value)
				flag($sformatf("final_value expected %h actual %h",
					exp.final_value, got.final_value));
			if (got.lowest !== exp.lowest)
				flag($sformatf("lowest expected %h actual %h", exp.lowest, got.lowest));
		endfunction

		// results never delivered count as failures
		function void close_out();
			while (owed_q.size() != 0) begin
				void'(owed_q.pop_front());
				flag("translate transaction never answered");
			end
		endfunction
	endclass

	remap_scoreboard sb;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none in no-idle stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t build(logic [1:0] k, logic [2:0] stg, logic [31:0] d,
			logic [31:0] s, logic [31:0] n, logic [31:0] v);
		item_t it;
		it.kind       = k;
		it.stage      = stg;
		it.dest_start = d;
		it.src_start  = s;
		it.span       = n;
		it.value      = v;
		return it;
	endfunction

	// load entry with source and destination mostly in a window above base
	function automatic item_t load_near(logic [31:0] base, logic [2:0] stg);
		logic [31:0] d, s, n;
		d = base + $urandom_range(0, 1023);
		s = base + $urandom_range(0, 1023);
		n = $urandom_range(1, 256);
		case ($urandom_range(0, 9))
			0: n = '0;
			1: n = $urandom;
			2: begin
				d = $urandom;
				s = $urandom;
			end
			3: d = 32'hFFFF_FFFF - $urandom_range(0, 200);
			default: ;
		endcase
		return build(KIND_LOAD, stg, d, s, n, $urandom);
	endfunction

	function automatic item_t xlate_near(logic [31:0] base);
		logic [31:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1: v = '1;
			2, 3, 4: v = $urandom;
			default: v = base + $urandom_range(0, 1100);
		endcase
		return build(KIND_XLATE, STAGE_W'($urandom), $urandom, $urandom, $urandom, v);
	endfunction

	// present one transaction and hold it until taken
	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		if (it.kind != KIND_SPARE && !(it.kind == KIND_LOAD && it.stage >= STAGES))
			counted++;
	endtask

	// sender holds off until the block has answered everything
	task automatic drain_pause();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// clear in most episodes, fill tables around one window with some translates mixed in, then translate through them
	task automatic remap_episode(input bit fill_one);
		logic [31:0] base;
		logic [2:0]  stg;
		logic [2:0]  target;
		base = $urandom;
		if ($urandom_range(0, 3) != 0)
			send_item(build(KIND_CLEAR, STAGE_W'($urandom), $urandom, $urandom, $urandom,
				$urandom));
		if (fill_one) begin
			target = STAGE_W'($urandom_range(0, STAGES - 1));
			repeat (ENTRIES + 3) send_item(load_near(base, target));
		end
		repeat ($urandom_range(0, 20)) begin
			stg = ($urandom_range(0, 19) == 0) ? STAGE_BEYOND :
				STAGE_W'($urandom_range(0, STAGES - 1));
			send_item(load_near(base, stg));
			if ($urandom_range(0, 5) == 0)
				send_item(xlate_near(base));
		end
		repeat ($urandom_range(3, 14)) send_item(xlate_near(base));
	endtask

	// unstructured transactions, unused kind included
	task automatic noise_burst();
		int unsigned r;
		repeat ($urandom_range(4, 16)) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				send_item(build(KIND_CLEAR, STAGE_W'($urandom), $urandom, $urandom,
					$urandom, $urandom));
			else if (r < 40)
				send_item(build(KIND_LOAD, STAGE_W'($urandom), $urandom, $urandom,
					$urandom, $urandom));
			else if (r < 85)
				send_item(build(KIND_XLATE, STAGE_W'($urandom), $urandom, $urandom,
					$urandom, $urandom));
			else
				send_item(build(KIND_SPARE, STAGE_W'($urandom), $urandom, $urandom,
					$urandom, $urandom));
		end
	endtask

	// result side back pressure
	always @(negedge clk) begin
		if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0)
			stall_left = pick_gap();
		result_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	// accepted transactions on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// ends the run when neither channel moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
		$display("chained_range_remap_top_test: errors");
		$finish;
	end

	// stimulus and end of run
	initial begin : stimulus
		int unsigned episode;
		sb = new();
		stall_left = 0;
		counted = 0;
		no_idle = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty tables pass values through; minimum tracks them
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'hFFFF_FFFF));
		send_item(build(KIND_XLATE, '1, '1, '1, '1, 32'h0));
		send_item(build(KIND_CLEAR, '1, '1, '1, '1, '1));
		// overlapping entries, zero span, wrapping destination, top of range
		send_item(build(KIND_LOAD, 3'd0, 32'd100, 32'd10, 32'd5, '0));
		send_item(build(KIND_LOAD, 3'd0, 32'd0, 32'd12, 32'd10, '0));
		send_item(build(KIND_LOAD, 3'd3, 32'd7, 32'd50, 32'd0, '0));
		send_item(build(KIND_LOAD, 3'd6, 32'hFFFF_FFF0, 32'h200, 32'h20, '0));
		send_item(build(KIND_LOAD, 3'd2, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
		// stage past the last table and unused kind change nothing
		send_item(build(KIND_LOAD, STAGE_BEYOND, 32'd5, 32'd0, 32'hFFFF_FFFF, '0));
		send_item(build(KIND_SPARE, '1, '1, '1, '1, '1));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'd10));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'd14));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'd15));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'd50));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'h21F));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'h220));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'hFFFF_FFFF));
		send_item(build(KIND_LOAD, 3'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, '0));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'd0));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'hFFFF_FFFE));
		send_item(build(KIND_CLEAR, '0, '0, '0, '0, '0));
		send_item(build(KIND_XLATE, '0, '0, '0, '0, 32'd7));
		drain_pause();

		// random episodes, first one fills a stage past its capacity
		episode = 0;
		while (counted < ITEM_GOAL) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if (episode != 0 && $urandom_range(0, 4) == 0)
				noise_burst();
			else
				remap_episode(episode == 0 || $urandom_range(0, 9) == 0);
			episode++;
			if (episode % 9 == 4)
				drain_pause();
		end

		@(negedge clk);
		item_valid <= 1'b0;
		no_idle = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();

		$display("covered %0d transactions, %0d translations checked, %0d clears",
			counted, sb.checked, sb.clears);
		$display("stored %0d entries (deepest stage %0d), %0d dropped when full, %0d ignored",
			sb.stored, sb.deepest, sb.dropped, sb.ignored);
		if (sb.errors == 0)
			$display("chained_range_remap_top_test: clean");
		else
			$display("chained_range_remap_top_test: errors");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/crr_pkg.sv
sv/crr_ram.sv
sv/crr_front.sv
sv/crr_queue.sv
sv/crr_back.sv
sv/chained_range_remap_top.sv
tb/chained_range_remap_top_test.sv
